>>> design/cau_pkg.sv
// Shared constants for the complex arithmetic unit: field widths, stream bus
// layout, operation codes and status codes. Depends on nothing.
package cau_pkg;

    localparam int FIELD_W = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // Input beat layout, lowest bit first.
    localparam int OPC_LSB  = 0;
    localparam int A_RE_LSB = OPC_LSB + OP_W;
    localparam int A_IM_LSB = A_RE_LSB + FIELD_W;
    localparam int B_RE_LSB = A_IM_LSB + FIELD_W;
    localparam int B_IM_LSB = B_RE_LSB + FIELD_W;
    localparam int S_USED_W = B_IM_LSB + FIELD_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // Output beat layout, lowest bit first.
    localparam int M_USED_W  = 2 * FIELD_W + 1 + ST_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_MAG = 3'd4;
    localparam logic [OP_W-1:0] OP_EQ  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_DZ  = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT = 2'd2;

endpackage

>>> design/cau_divsqrt.sv
// Pipelined restoring divider pair and square root, one quotient bit and one
// root bit per stage. Stand-alone; parameters come from the top level.
module cau_divsqrt
#(
    parameter int WE        = 32,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [2*WE-1:0]   in_den,
    input  logic [2*WE-1:0]   in_mag_re,
    input  logic [2*WE-1:0]   in_mag_im,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [WE-1:0]     out_q_re,
    output logic [WE-1:0]     out_q_im,
    output logic [WE-1:0]     out_root,
    output logic              out_ovf_re,
    output logic              out_ovf_im,
    output logic [SIDE_W-1:0] out_side
);

    localparam int MW = 2 * WE;
    localparam int NW = MW + FRAC_BITS;
    localparam int HW = NW - WE;
    localparam int RR = WE + 2;
    localparam int RC = WE + 4;

    logic [NW-1:0] n_re;
    logic [NW-1:0] n_im;
    logic [HW-1:0] hi_re;
    logic [HW-1:0] hi_im;
    logic          ovf_re0;
    logic          ovf_im0;

    logic [MW-1:0]     den_reg    [0:WE];
    logic [MW-1:0]     r_re_reg   [0:WE];
    logic [MW-1:0]     r_im_reg   [0:WE];
    logic [WE-1:0]     lo_re_reg  [0:WE];
    logic [WE-1:0]     lo_im_reg  [0:WE];
    logic [WE-1:0]     q_re_reg   [0:WE];
    logic [WE-1:0]     q_im_reg   [0:WE];
    logic [WE-1:0]     root_reg   [0:WE];
    logic [RR-1:0]     rem_reg    [0:WE];
    logic              ovf_re_reg [0:WE];
    logic              ovf_im_reg [0:WE];
    logic [SIDE_W-1:0] side_reg   [0:WE];
    logic              v_reg      [0:WE];

    // The scaled numerator is checked against the divisor shifted up by the
    // quotient width, so that a quotient which cannot fit is flagged at once.
    always_comb
    begin
        n_re    = NW'(in_mag_re) << FRAC_BITS;
        n_im    = NW'(in_mag_im) << FRAC_BITS;
        hi_re   = n_re[NW-1:WE];
        hi_im   = n_im[NW-1:WE];
        ovf_re0 = NW'(hi_re) >= NW'(in_den);
        ovf_im0 = NW'(hi_im) >= NW'(in_den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            den_reg[0]    <= in_den;
            r_re_reg[0]   <= MW'(hi_re);
            r_im_reg[0]   <= MW'(hi_im);
            lo_re_reg[0]  <= n_re[WE-1:0];
            lo_im_reg[0]  <= n_im[WE-1:0];
            q_re_reg[0]   <= '0;
            q_im_reg[0]   <= '0;
            root_reg[0]   <= '0;
            rem_reg[0]    <= '0;
            ovf_re_reg[0] <= ovf_re0;
            ovf_im_reg[0] <= ovf_im0;
            side_reg[0]   <= in_side;
        end
    end

    for (genvar k = 0; k < WE; k++)
    begin : g_step
        localparam int BI = WE - 1 - k;

        logic [MW:0]   t_re;
        logic [MW:0]   t_im;
        logic          ge_re;
        logic          ge_im;
        logic [RC-1:0] t_sq;
        logic [RC-1:0] trial;
        logic          ge_sq;

        always_comb
        begin
            t_re  = {r_re_reg[k], lo_re_reg[k][BI]};
            t_im  = {r_im_reg[k], lo_im_reg[k][BI]};
            ge_re = t_re >= {1'b0, den_reg[k]};
            ge_im = t_im >= {1'b0, den_reg[k]};
            t_sq  = {rem_reg[k], den_reg[k][2*BI+1 -: 2]};
            trial = RC'({root_reg[k], 2'b01});
            ge_sq = t_sq >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (ce)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                den_reg[k+1]    <= den_reg[k];
                r_re_reg[k+1]   <= ge_re ? MW'(t_re - {1'b0, den_reg[k]}) : t_re[MW-1:0];
                r_im_reg[k+1]   <= ge_im ? MW'(t_im - {1'b0, den_reg[k]}) : t_im[MW-1:0];
                lo_re_reg[k+1]  <= lo_re_reg[k];
                lo_im_reg[k+1]  <= lo_im_reg[k];
                q_re_reg[k+1]   <= {q_re_reg[k][WE-2:0], ge_re};
                q_im_reg[k+1]   <= {q_im_reg[k][WE-2:0], ge_im};
                rem_reg[k+1]    <= ge_sq ? RR'(t_sq - trial) : t_sq[RR-1:0];
                root_reg[k+1]   <= {root_reg[k][WE-2:0], ge_sq};
                ovf_re_reg[k+1] <= ovf_re_reg[k];
                ovf_im_reg[k+1] <= ovf_im_reg[k];
                side_reg[k+1]   <= side_reg[k];
            end
        end
    end

    assign out_valid  = v_reg[WE];
    assign out_q_re   = q_re_reg[WE];
    assign out_q_im   = q_im_reg[WE];
    assign out_root   = root_reg[WE];
    assign out_ovf_re = ovf_re_reg[WE];
    assign out_ovf_im = ovf_im_reg[WE];
    assign out_side   = side_reg[WE];

endmodule

>>> design/complex_arithmetic_unit_top.sv
// Complex arithmetic unit top level: operand registers, multipliers, sums and
// saturation around the pipelined divider and square root.
// Depends on cau_pkg and cau_divsqrt.
//
//   Channel   Direction   Beat contents
//   s_*       in          opcode, a_re, a_im, b_re, b_im
//   m_*       out         res_re, res_im, is_equal, status
//
// One beat is taken in every cycle while no result is held back; each result
// runs through the operand, product, sum, magnitude, divider and output registers.
// Reset clears only the valid bits. When a finished result is held back, the
// whole pipeline halts and nothing is lost or repeated.
module complex_arithmetic_unit_top
    import cau_pkg::*;
#(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // opcode, a_re, a_im, b_re, b_im
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // res_re, res_im, is_equal, status
);

    localparam int WE     = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam int MW     = 2 * WE;
    localparam int SIDE_W = 2 * WE + OP_W + 5;
    localparam logic [MW-1:0] LIM = MW'(1) << (WE - 1);

    function automatic logic [WE:0] clamp_sm(input logic neg, input logic [MW-1:0] m);
        logic          sat;
        logic [WE-1:0] val;
        if (neg)
        begin
            sat = m > LIM;
            val = sat ? WE'(LIM) : WE'(MW'(0) - m);
        end
        else
        begin
            sat = m > (LIM - MW'(1));
            val = sat ? WE'(LIM - MW'(1)) : WE'(m);
        end
        return {sat, val};
    endfunction

    logic ce;

    logic                 v1_reg;
    logic [OP_W-1:0]      op1_reg;
    logic signed [WE-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg, x51_reg, x61_reg;

    logic                 v2_reg;
    logic [OP_W-1:0]      op2_reg;
    logic signed [MW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [WE:0]   as_re2_reg, as_im2_reg;
    logic                 eq2_reg;

    logic                 v3_reg;
    logic [OP_W-1:0]      op3_reg;
    logic signed [MW:0]   sre3_reg, sim3_reg;
    logic [MW-1:0]        n3_reg;
    logic [WE-1:0]        as_re3_reg, as_im3_reg;
    logic                 as_sat3_reg;
    logic                 eq3_reg;

    logic                 v4_reg;
    logic [OP_W-1:0]      op4_reg;
    logic                 neg_re4_reg, neg_im4_reg;
    logic [MW-1:0]        mag_re4_reg, mag_im4_reg, n4_reg;
    logic [WE-1:0]        as_re4_reg, as_im4_reg;
    logic                 as_sat4_reg;
    logic                 eq4_reg;

    logic signed [MW-1:0] se_re, se_im;
    logic [WE:0]          as_c_re, as_c_im;

    logic [WE:0]          mul_c_re, mul_c_im;
    logic [WE-1:0]        e_re, e_im;
    logic                 e_sat, e_eq, dz;
    logic [SIDE_W-1:0]    side_in;

    logic                 d_valid;
    logic [WE-1:0]        q_re, q_im, root;
    logic                 ovf_re, ovf_im;
    logic [SIDE_W-1:0]    side_out;

    logic [OP_W-1:0]      f_op;
    logic                 f_neg_re, f_neg_im, f_dz;
    logic [WE:0]          c_re, c_im;
    logic [WE-1:0]        f_re, f_im;
    logic                 f_eq;
    logic [ST_W-1:0]      f_st;

    logic                 m_tvalid_reg;
    logic [FIELD_W-1:0]   res_re_reg, res_im_reg;
    logic                 is_equal_reg;
    logic [ST_W-1:0]      status_reg;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            m_tvalid_reg <= d_valid;
        end
    end

    // Operand capture; the squaring multipliers serve b for division and a
    // for the magnitude.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            op1_reg <= s_tdata[OPC_LSB +: OP_W];
            ar1_reg <= s_tdata[A_RE_LSB +: WE];
            ai1_reg <= s_tdata[A_IM_LSB +: WE];
            br1_reg <= s_tdata[B_RE_LSB +: WE];
            bi1_reg <= s_tdata[B_IM_LSB +: WE];
            x51_reg <= (s_tdata[OPC_LSB +: OP_W] == OP_MAG) ? s_tdata[A_RE_LSB +: WE]
                                                            : s_tdata[B_RE_LSB +: WE];
            x61_reg <= (s_tdata[OPC_LSB +: OP_W] == OP_MAG) ? s_tdata[A_IM_LSB +: WE]
                                                            : s_tdata[B_IM_LSB +: WE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            op2_reg    <= op1_reg;
            p1_reg     <= ar1_reg * br1_reg;
            p2_reg     <= ai1_reg * bi1_reg;
            p3_reg     <= ar1_reg * bi1_reg;
            p4_reg     <= ai1_reg * br1_reg;
            p5_reg     <= x51_reg * x51_reg;
            p6_reg     <= x61_reg * x61_reg;
            as_re2_reg <= (op1_reg == OP_SUB) ? (ar1_reg - br1_reg) : (ar1_reg + br1_reg);
            as_im2_reg <= (op1_reg == OP_SUB) ? (ai1_reg - bi1_reg) : (ai1_reg + bi1_reg);
            eq2_reg    <= (ar1_reg == br1_reg) && (ai1_reg == bi1_reg);
        end
    end

    always_comb
    begin
        se_re   = MW'(as_re2_reg);
        se_im   = MW'(as_im2_reg);
        as_c_re = clamp_sm(as_re2_reg[WE], as_re2_reg[WE] ? MW'(-se_re) : MW'(se_re));
        as_c_im = clamp_sm(as_im2_reg[WE], as_im2_reg[WE] ? MW'(-se_im) : MW'(se_im));
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            op3_reg     <= op2_reg;
            sre3_reg    <= (op2_reg == OP_MUL) ? (p1_reg - p2_reg) : (p1_reg + p2_reg);
            sim3_reg    <= (op2_reg == OP_MUL) ? (p3_reg + p4_reg) : (p4_reg - p3_reg);
            n3_reg      <= $unsigned(p5_reg) + $unsigned(p6_reg);
            as_re3_reg  <= as_c_re[WE-1:0];
            as_im3_reg  <= as_c_im[WE-1:0];
            as_sat3_reg <= as_c_re[WE] | as_c_im[WE];
            eq3_reg     <= eq2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            op4_reg     <= op3_reg;
            neg_re4_reg <= sre3_reg[MW];
            neg_im4_reg <= sim3_reg[MW];
            mag_re4_reg <= MW'(sre3_reg[MW] ? -sre3_reg : sre3_reg);
            mag_im4_reg <= MW'(sim3_reg[MW] ? -sim3_reg : sim3_reg);
            n4_reg      <= n3_reg;
            as_re4_reg  <= as_re3_reg;
            as_im4_reg  <= as_im3_reg;
            as_sat4_reg <= as_sat3_reg;
            eq4_reg     <= eq3_reg;
        end
    end

    // Results that need no division are settled here and ride alongside.
    always_comb
    begin
        mul_c_re = clamp_sm(neg_re4_reg, mag_re4_reg >> FRAC_BITS);
        mul_c_im = clamp_sm(neg_im4_reg, mag_im4_reg >> FRAC_BITS);
        dz       = (n4_reg == '0);
        e_re     = '0;
        e_im     = '0;
        e_sat    = 1'b0;
        e_eq     = 1'b0;
        case (op4_reg)
            OP_ADD, OP_SUB:
            begin
                e_re  = as_re4_reg;
                e_im  = as_im4_reg;
                e_sat = as_sat4_reg;
            end
            OP_MUL:
            begin
                e_re  = mul_c_re[WE-1:0];
                e_im  = mul_c_im[WE-1:0];
                e_sat = mul_c_re[WE] | mul_c_im[WE];
            end
            OP_EQ:
            begin
                e_eq = eq4_reg;
            end
            default:
            begin
                e_eq = 1'b0;
            end
        endcase
        side_in = {e_re, e_im, op4_reg, neg_re4_reg, neg_im4_reg, dz, e_sat, e_eq};
    end

    cau_divsqrt
    #(
        .WE        (WE),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    )
    u_divsqrt
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ce         (ce),
        .in_valid   (v4_reg),
        .in_den     (n4_reg),
        .in_mag_re  (mag_re4_reg),
        .in_mag_im  (mag_im4_reg),
        .in_side    (side_in),
        .out_valid  (d_valid),
        .out_q_re   (q_re),
        .out_q_im   (q_im),
        .out_root   (root),
        .out_ovf_re (ovf_re),
        .out_ovf_im (ovf_im),
        .out_side   (side_out)
    );

    always_comb
    begin
        f_op     = side_out[5 +: OP_W];
        f_neg_re = side_out[4];
        f_neg_im = side_out[3];
        f_dz     = side_out[2];
        c_re     = {side_out[1], side_out[5 + OP_W + WE +: WE]};
        c_im     = {1'b0, side_out[5 + OP_W +: WE]};
        f_eq     = side_out[0];
        case (f_op)
            OP_DIV:
            begin
                f_eq = 1'b0;
                if (f_dz)
                begin
                    c_re = '0;
                    c_im = '0;
                end
                else
                begin
                    c_re = clamp_sm(f_neg_re, ovf_re ? (LIM + MW'(1)) : MW'(q_re));
                    c_im = clamp_sm(f_neg_im, ovf_im ? (LIM + MW'(1)) : MW'(q_im));
                end
            end
            OP_MAG:
            begin
                f_eq = 1'b0;
                c_re = clamp_sm(1'b0, MW'(root));
                c_im = '0;
            end
            default:
            begin
                c_im = {1'b0, side_out[5 + OP_W +: WE]};
            end
        endcase
        f_re = c_re[WE-1:0];
        f_im = c_im[WE-1:0];
        if ((f_op == OP_DIV) && f_dz)
        begin
            f_st = ST_DZ;
        end
        else if (c_re[WE] || c_im[WE])
        begin
            f_st = ST_SAT;
        end
        else
        begin
            f_st = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            res_re_reg   <= FIELD_W'(signed'(f_re));
            res_im_reg   <= FIELD_W'(signed'(f_im));
            is_equal_reg <= f_eq;
            status_reg   <= f_st;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, status_reg, is_equal_reg, res_im_reg, res_re_reg};

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (status_reg == ST_DZ)) |->
            ((res_re_reg == '0) && (res_im_reg == '0) && !is_equal_reg))
        else $error("Division by zero result is not cleared.");

    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && is_equal_reg) |->
            ((status_reg == ST_OK) && (res_re_reg == '0) && (res_im_reg == '0)))
        else $error("Equality result carries data or status.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!ce) |=> ($stable(v4_reg) && $stable(d_valid)))
        else $error("Pipeline moved while halted.");

endmodule

>>> tb/sv/complex_arithmetic_unit_top_test.sv
// Self-checking testbench for complex_arithmetic_unit_top: directed table, then random beats,
// each result compared with its table value or an in-bench fixed-point predictor.
// Depends on cau_pkg and the complex_arithmetic_unit_top RTL.
`timescale 1ns / 1ps

module complex_arithmetic_unit_top_test;
    import cau_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 2000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic signed [FIELD_W-1:0] re;
        logic signed [FIELD_W-1:0] im;
        logic                      eq;
        logic [ST_W-1:0]           st;
    } outcome_t;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [FIELD_W-1:0] ar, ai, br, bi;
        bit                        typed;
        outcome_t                  want;
    } vector_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // opcode, a_re, a_im, b_re, b_im
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // res_re, res_im, is_equal, status

    outcome_t pending_results[$];
    vector_t  directed[$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       beats_sent = 0;
    int       cycles = 0;

    complex_arithmetic_unit_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic signed [FIELD_W-1:0] clamp_part(input logic neg,
                                                             input logic [95:0] mag,
                                                             inout bit sat);
        if (neg)
        begin
            if (mag > 96'h8000_0000)
            begin
                sat = 1'b1;
                return 32'sh8000_0000;
            end
            return -mag[31:0];
        end
        if (mag > 96'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic outcome_t compute_result(input logic [OP_W-1:0] op,
                                                input logic signed [FIELD_W-1:0] ar, ai,
                                                input logic signed [FIELD_W-1:0] br, bi);
        logic signed [65:0] s0, s1, den;
        logic [95:0]        m0, m1;
        bit                 sat;
        outcome_t           r;
        r = '0;
        sat = 1'b0;
        s0 = 66'(ar) * 66'(br) - 66'(ai) * 66'(bi);
        s1 = 66'(ar) * 66'(bi) + 66'(ai) * 66'(br);
        case (op)
            OP_ADD:
            begin
                s0 = 66'(ar) + 66'(br);
                s1 = 66'(ai) + 66'(bi);
                r.re = clamp_part(s0 < 0, 96'(s0 < 0 ? -s0 : s0), sat);
                r.im = clamp_part(s1 < 0, 96'(s1 < 0 ? -s1 : s1), sat);
            end
            OP_SUB:
            begin
                s0 = 66'(ar) - 66'(br);
                s1 = 66'(ai) - 66'(bi);
                r.re = clamp_part(s0 < 0, 96'(s0 < 0 ? -s0 : s0), sat);
                r.im = clamp_part(s1 < 0, 96'(s1 < 0 ? -s1 : s1), sat);
            end
            OP_MUL:
            begin
                r.re = clamp_part(s0 < 0, 96'(s0 < 0 ? -s0 : s0) >> DEF_FRAC_BITS, sat);
                r.im = clamp_part(s1 < 0, 96'(s1 < 0 ? -s1 : s1) >> DEF_FRAC_BITS, sat);
            end
            OP_DIV:
            begin
                den = 66'(br) * 66'(br) + 66'(bi) * 66'(bi);
                if (den == 0)
                    r.st = ST_DZ;
                else
                begin
                    s0 = 66'(ar) * 66'(br) + 66'(ai) * 66'(bi);
                    s1 = 66'(ai) * 66'(br) - 66'(ar) * 66'(bi);
                    m0 = (96'(s0 < 0 ? -s0 : s0) << DEF_FRAC_BITS) / 96'(den);
                    m1 = (96'(s1 < 0 ? -s1 : s1) << DEF_FRAC_BITS) / 96'(den);
                    r.re = clamp_part(s0 < 0, m0, sat);
                    r.im = clamp_part(s1 < 0, m1, sat);
                end
            end
            OP_MAG:
            begin
                den = 66'(ar) * 66'(ar) + 66'(ai) * 66'(ai);
                r.re = clamp_part(1'b0, 96'(int_sqrt(den[63:0])), sat);
            end
            OP_EQ:
                r.eq = (ar == br) && (ai == bi);
            default:
                r = '0;
        endcase
        if (r.st == ST_OK && sat)
            r.st = ST_SAT;
        return r;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic [31:0] ar, ai, br, bi,
                           input bit typed, input outcome_t want);
        vector_t v;
        v.op = op;
        v.ar = ar;
        v.ai = ai;
        v.br = br;
        v.bi = bi;
        v.typed = typed;
        v.want = want;
        directed.push_back(v);
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input vector_t v);
        if (beats_sent > 20 && (beats_sent < 800 || beats_sent > 1100))
        begin
            while ($urandom_range(0, 99) < 9)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - S_USED_W){1'b0}}, v.bi, v.br, v.ai, v.ar, v.op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(v.typed ? v.want
                                          : compute_result(v.op, v.ar, v.ai, v.br, v.bi));
        beats_sent++;
    endtask

    initial
    begin
        vector_t v;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        add_row(OP_ADD, 0, 0, 0, 0, 1'b1, '{0, 0, 1'b0, ST_OK});
        add_row(OP_ADD, 32'h7FFF_FFFF, 0, 32'h0001_0000, 0, 1'b1,
                '{32'sh7FFF_FFFF, 0, 1'b0, ST_SAT});
        add_row(OP_SUB, 32'h8000_0000, 0, 1, 0, 1'b1, '{32'sh8000_0000, 0, 1'b0, ST_SAT});
        add_row(OP_SUB, 32'h0001_0000, 0, 32'h0002_0000, 32'h0003_0000, 1'b0, '0);
        add_row(OP_MUL, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'hFFFF_0000, 1'b0, '0);
        add_row(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0);
        add_row(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);
        add_row(OP_MUL, 32'hFFFF_FFFF, 0, 1, 0, 1'b0, '0);
        add_row(OP_DIV, 32'h0001_0000, 32'h0002_0000, 0, 0, 1'b1, '{0, 0, 1'b0, ST_DZ});
        add_row(OP_DIV, 32'h0001_0000, 0, 32'h0003_0000, 0, 1'b0, '0);
        add_row(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 1'b0, '0);
        add_row(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0);
        add_row(OP_DIV, 32'h0005_0000, 32'hFFFD_0000, 32'h0001_0000, 32'h0002_0000, 1'b0, '0);
        add_row(OP_MAG, 32'h0003_0000, 32'h0004_0000, 0, 0, 1'b1,
                '{32'sh0005_0000, 0, 1'b0, ST_OK});
        add_row(OP_MAG, 32'h8000_0000, 32'h8000_0000, 0, 0, 1'b1,
                '{32'sh7FFF_FFFF, 0, 1'b0, ST_SAT});
        add_row(OP_MAG, 32'h8000_0000, 0, 0, 0, 1'b0, '0);
        add_row(OP_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000, 1'b1,
                '{0, 0, 1'b1, ST_OK});
        add_row(OP_EQ, 32'h1234_5678, 0, 32'h1234_5678, 1, 1'b1, '{0, 0, 1'b0, ST_OK});
        add_row(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0);
        add_row(3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 1, 2, 1'b1, '0);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i]) send_beat(directed[i]);
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == 1500)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0) @(posedge clk);
            end
            v.op = OP_W'($urandom_range(0, 7));
            v.ar = random_operand();
            v.ai = random_operand();
            v.br = random_operand();
            v.bi = $urandom_range(0, 9) == 0 ? 32'h0 : random_operand();
            if (v.op == OP_EQ && $urandom_range(0, 1))
            begin
                v.br = v.ar;
                v.bi = $urandom_range(0, 2) == 0 ? random_operand() : v.ai;
            end
            if (v.op == OP_DIV && $urandom_range(0, 9) == 0)
            begin
                v.br = 0;
                v.bi = 0;
            end
            v.typed = 1'b0;
            send_beat(v);
        end
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d beats over all eight opcodes (directed extremes, then random);",
                 beats_sent);
        $display("checked %0d results under random and long back-pressure.", results_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // The receiver runs on its own count, with one long hold-off and one stretch always ready.
    initial
    begin
        int rx_cycles;
        rx_cycles = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles >= 1000 && rx_cycles < 1400)
                m_tready <= 1'b0;
            else if (rx_cycles >= 1600 && rx_cycles < 2100)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        outcome_t got, want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
                     pending_results.size());
            $display("FAILURE");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[64], m_tdata[66:65]};
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: %h", m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.re !== want.re || got.im !== want.im || got.eq !== want.eq
                    || got.st !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d: expected %h %h %b %0d, got %h %h %b %0d",
                                 results_seen, want.re, want.im, want.eq, want.st,
                                 got.re, got.im, got.eq, got.st);
                end
            end
        end
    end

endmodule

>>> filelist.f
design/cau_pkg.sv
design/cau_divsqrt.sv
design/complex_arithmetic_unit_top.sv
tb/sv/complex_arithmetic_unit_top_test.sv
